### rtl/psma_pkg.sv
// shared constants, beat types, controller state and command/status structs
package psma_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int WINDOW        = 6;

   localparam int ADDR_HALF_W = 64;
   localparam int AVG_W       = 16;
   localparam int RSP_SLOT_W  = 4;
   localparam int RSP_FILL_W  = 3;

   localparam int IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SLOT_W     = $clog2(WINDOW);
   localparam int CNT_W      = $clog2(WINDOW + 1);
   localparam int SUM_W      = AVG_W + $clog2(WINDOW);
   localparam int HIST_DEPTH = TABLE_ENTRIES * WINDOW;
   localparam int HADDR_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int DIV_CNT_W  = $clog2(AVG_W);

   typedef struct packed {
      logic [ADDR_HALF_W-1:0] addr_high;
      logic [ADDR_HALF_W-1:0] addr_low;
      logic [AVG_W-1:0]       sample;
   } req_type;

   typedef struct packed {
      logic [AVG_W-1:0]      average;
      logic [RSP_SLOT_W-1:0] slot;
      logic [RSP_FILL_W-1:0] fill_count;
      logic                  table_full;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_INSERT,
      ST_WRITE,
      ST_READ,
      ST_DRAIN,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINISH,
      ST_FULL
   } psma_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic insert;
      logic write;
      logic read;
      logic div_init;
      logic div_step;
      logic emit_avg;
      logic emit_full;
   } psma_cmd_type;

   typedef struct packed {
      logic cur_valid;
      logic cur_match;
      logic idx_last;
      logic rd_last;
      logic div_last;
      logic out_busy;
   } psma_status_type;

endpackage

### rtl/per_source_moving_average.sv
// top level: per-sender moving average over the last WINDOW samples
// per request beat: the key search walks the table entries up to the hit or first
//   free entry, the history ram gives one read per held sample, the divider takes
//   16 steps; a full table skips the history update, reads and divide
// throughput: one item at a time, next request beat taken once the result is registered
// reset clears the controller, the entry valid bits and the result valid;
//   keys and history ram are not cleared
module per_source_moving_average (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psma_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psma_pkg::rsp_type rsp_data
);

   psma_pkg::psma_cmd_type    cmd;
   psma_pkg::psma_status_type status;

   psma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   psma_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/psma_ram.sv
// generic single-write, single-read ram with registered read data
module psma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 96
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/psma_ctrl.sv
// controller state machine: search, insert, history update, summing, divide, emit
module psma_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  psma_pkg::psma_status_type  status,
   output psma_pkg::psma_cmd_type     cmd
);

   psma_pkg::psma_state_type state_ff;
   psma_pkg::psma_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psma_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psma_pkg::ST_IDLE: begin
            if (req_valid) state_in = psma_pkg::ST_SEARCH;
         end
         psma_pkg::ST_SEARCH: begin
            // entries fill from the bottom, so the first free one ends the search
            priority if (!status.cur_valid) begin
               state_in = psma_pkg::ST_INSERT;
            end else if (status.cur_match) begin
               state_in = psma_pkg::ST_WRITE;
            end else if (status.idx_last) begin
               state_in = psma_pkg::ST_FULL;
            end else begin
               state_in = psma_pkg::ST_SEARCH;
            end
         end
         psma_pkg::ST_INSERT:   state_in = psma_pkg::ST_WRITE;
         psma_pkg::ST_WRITE:    state_in = psma_pkg::ST_READ;
         psma_pkg::ST_READ: begin
            if (status.rd_last) state_in = psma_pkg::ST_DRAIN;
         end
         psma_pkg::ST_DRAIN:    state_in = psma_pkg::ST_DIV_INIT;
         psma_pkg::ST_DIV_INIT: state_in = psma_pkg::ST_DIV;
         psma_pkg::ST_DIV: begin
            if (status.div_last) state_in = psma_pkg::ST_FINISH;
         end
         psma_pkg::ST_FINISH, psma_pkg::ST_FULL: begin
            if (!status.out_busy) state_in = psma_pkg::ST_IDLE;
         end
         default: state_in = psma_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         psma_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         psma_pkg::ST_SEARCH: begin
            cmd.step = status.cur_valid && !status.cur_match && !status.idx_last;
         end
         psma_pkg::ST_INSERT:   cmd.insert   = 1'b1;
         psma_pkg::ST_WRITE:    cmd.write    = 1'b1;
         psma_pkg::ST_READ:     cmd.read     = 1'b1;
         psma_pkg::ST_DRAIN:    cmd          = '0;
         psma_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
         psma_pkg::ST_DIV:      cmd.div_step = 1'b1;
         psma_pkg::ST_FINISH:   cmd.emit_avg  = !status.out_busy;
         psma_pkg::ST_FULL:     cmd.emit_full = !status.out_busy;
         default:               cmd          = '0;
      endcase
   end

endmodule

### rtl/psma_dp.sv
// datapath: sender table, history ram, running sum, restoring divider, result register
module psma_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  psma_pkg::psma_cmd_type     cmd,
   output psma_pkg::psma_status_type  status,
   input  psma_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output psma_pkg::rsp_type          rsp_data
);

   psma_pkg::req_type                      in_ff;
   logic [psma_pkg::IDX_W-1:0]             idx_ff;
   logic [psma_pkg::IDX_W-1:0]             idx_in;

   logic [2*psma_pkg::ADDR_HALF_W-1:0]     key_ff [psma_pkg::TABLE_ENTRIES];
   logic [psma_pkg::TABLE_ENTRIES-1:0]     valid_ff;
   logic [psma_pkg::CNT_W-1:0]             held_ff [psma_pkg::TABLE_ENTRIES];
   logic [psma_pkg::SLOT_W-1:0]            ptr_ff [psma_pkg::TABLE_ENTRIES];
   logic [2*psma_pkg::ADDR_HALF_W-1:0]     key_in;
   logic [psma_pkg::CNT_W-1:0]             held_in;
   logic [psma_pkg::SLOT_W-1:0]            ptr_in;

   logic [psma_pkg::CNT_W-1:0]             n_ff;
   logic [psma_pkg::SLOT_W-1:0]            rd_cnt_ff;
   logic [psma_pkg::SLOT_W-1:0]            rd_cnt_in;
   logic                                   rd_pend_ff;
   logic [psma_pkg::SUM_W-1:0]             sum_ff;
   logic [psma_pkg::SUM_W-1:0]             sum_in;

   logic [psma_pkg::CNT_W-1:0]             rem_ff;
   logic [psma_pkg::CNT_W-1:0]             rem_in;
   logic [psma_pkg::AVG_W-1:0]             quo_ff;
   logic [psma_pkg::AVG_W-1:0]             quo_in;
   logic [psma_pkg::DIV_CNT_W-1:0]         div_cnt_ff;
   logic [psma_pkg::DIV_CNT_W-1:0]         div_cnt_in;
   logic [psma_pkg::CNT_W:0]               trial;
   logic                                   trial_ge;

   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   psma_pkg::rsp_type                      rsp_data_ff;
   psma_pkg::rsp_type                      rsp_data_in;

   logic [psma_pkg::HADDR_W-1:0]           hist_base;
   logic [psma_pkg::HADDR_W-1:0]           hist_wr_addr;
   logic [psma_pkg::HADDR_W-1:0]           hist_rd_addr;
   logic [psma_pkg::AVG_W-1:0]             hist_rd_data;

   // sender table
   assign key_in = {in_ff.addr_high, in_ff.addr_low};

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.step) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      held_in = held_ff[idx_ff];
      if (held_ff[idx_ff] != psma_pkg::CNT_W'(psma_pkg::WINDOW)) begin
         held_in = held_ff[idx_ff] + 1'b1;
      end
      ptr_in = ptr_ff[idx_ff] + 1'b1;
      if (ptr_ff[idx_ff] == psma_pkg::SLOT_W'(psma_pkg::WINDOW - 1)) begin
         ptr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.insert) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_data;
      end
      idx_ff <= idx_in;
      if (cmd.insert) begin
         key_ff[idx_ff]  <= key_in;
         held_ff[idx_ff] <= '0;
         ptr_ff[idx_ff]  <= '0;
      end else if (cmd.write) begin
         held_ff[idx_ff] <= held_in;
         ptr_ff[idx_ff]  <= ptr_in;
      end
      if (cmd.write) begin
         n_ff <= held_in;
      end
   end

   // history: each entry owns WINDOW slots, written round robin, so the held
   // samples always sit in the first n slots of the entry
   assign hist_base    = psma_pkg::HADDR_W'(idx_ff) * psma_pkg::HADDR_W'(psma_pkg::WINDOW);
   assign hist_wr_addr = hist_base + psma_pkg::HADDR_W'(ptr_ff[idx_ff]);
   assign hist_rd_addr = hist_base + psma_pkg::HADDR_W'(rd_cnt_ff);

   psma_ram #(
      .WIDTH(psma_pkg::AVG_W),
      .DEPTH(psma_pkg::HIST_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (hist_wr_addr),
      .wr_data (in_ff.sample),
      .rd_en   (cmd.read),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   always_comb begin
      rd_cnt_in = rd_cnt_ff;
      sum_in    = sum_ff;
      if (cmd.write) begin
         rd_cnt_in = '0;
         sum_in    = '0;
      end else begin
         if (cmd.read) rd_cnt_in = rd_cnt_ff + 1'b1;
         if (rd_pend_ff) sum_in = sum_ff + psma_pkg::SUM_W'(hist_rd_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.read;
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff <= rd_cnt_in;
      sum_ff    <= sum_in;
   end

   // restoring divider; the mean fits in AVG_W bits so the top sum bits
   // start as the remainder
   assign trial    = {rem_ff, quo_ff[psma_pkg::AVG_W-1]};
   assign trial_ge = trial >= {1'b0, n_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_init) begin
         rem_in     = psma_pkg::CNT_W'(sum_ff[psma_pkg::SUM_W-1:psma_pkg::AVG_W]);
         quo_in     = sum_ff[psma_pkg::AVG_W-1:0];
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in     = trial_ge ? psma_pkg::CNT_W'(trial - {1'b0, n_ff})
                               : psma_pkg::CNT_W'(trial);
         quo_in     = {quo_ff[psma_pkg::AVG_W-2:0], trial_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_cnt_ff <= div_cnt_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit_avg) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.average    = quo_ff;
         rsp_data_in.slot       = psma_pkg::RSP_SLOT_W'(idx_ff);
         rsp_data_in.fill_count = psma_pkg::RSP_FILL_W'(n_ff);
         rsp_data_in.table_full = 1'b0;
      end else if (cmd.emit_full) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in            = '0;
         rsp_data_in.table_full = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.cur_valid = valid_ff[idx_ff];
   assign status.cur_match = key_ff[idx_ff] == key_in;
   assign status.idx_last  = idx_ff == psma_pkg::IDX_W'(psma_pkg::TABLE_ENTRIES - 1);
   assign status.rd_last   = (psma_pkg::CNT_W'(rd_cnt_ff) + 1'b1) == n_ff;
   assign status.div_last  = div_cnt_ff == psma_pkg::DIV_CNT_W'(psma_pkg::AVG_W - 1);
   assign status.out_busy  = rsp_valid_ff && rsp_stall;

`ifndef SYNTH
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_avg || cmd.emit_full) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result written over a stalled beat");

   a_read_count: assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> (n_ff != '0) && (n_ff <= psma_pkg::CNT_W'(psma_pkg::WINDOW)))
      else $error("history read with bad fill count");

   a_quo_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |-> (psma_pkg::CNT_W'(sum_ff[psma_pkg::SUM_W-1:psma_pkg::AVG_W]) < n_ff))
      else $error("sum too large for its fill count");

   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !valid_ff[idx_ff])
      else $error("insert over a valid entry");
`endif

endmodule

### tb/sv/psma_average_checker.sv
// checker: predicts each result beat of the moving average block and compares it
`timescale 1ns / 100ps

module psma_average_checker
   import psma_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending,
   output int      checked,
   output int      full_seen
);

   localparam int PRINT_CAP = 30;

   // predictor copy of the sender table and histories
   logic [2*ADDR_HALF_W-1:0] sender_key    [TABLE_ENTRIES];
   logic                     sender_live   [TABLE_ENTRIES];
   logic [AVG_W-1:0]         level_history [TABLE_ENTRIES][WINDOW];
   int                       held_count    [TABLE_ENTRIES];

   rsp_type averages_due[$];
   int      mismatches = 0;
   int      results_seen = 0;
   int      full_results = 0;

   assign fail_count = mismatches;
   assign checked    = results_seen;
   assign full_seen  = full_results;

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP)
         $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic rsp_type next_average(input req_type beat);
      logic [2*ADDR_HALF_W-1:0] key;
      logic [31:0]              total;
      rsp_type                  res;
      int                       hit;
      int                       spare;
      int                       i;
      key   = {beat.addr_high, beat.addr_low};
      hit   = -1;
      spare = -1;
      total = '0;
      res   = '0;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
         if (sender_live[i]) begin
            if (hit < 0 && sender_key[i] == key)
               hit = i;
         end else if (spare < 0) begin
            spare = i;
         end
      end
      // new sender takes the lowest free entry
      if (hit < 0 && spare >= 0) begin
         sender_key[spare]  = key;
         sender_live[spare] = 1'b1;
         held_count[spare]  = 0;
         hit = spare;
      end
      if (hit < 0) begin
         res.table_full = 1'b1;
      end else begin
         for (i = WINDOW - 1; i > 0; i--)
            level_history[hit][i] = level_history[hit][i-1];
         level_history[hit][0] = beat.sample;
         if (held_count[hit] < WINDOW)
            held_count[hit]++;
         for (i = 0; i < held_count[hit]; i++)
            total += level_history[hit][i];
         res.average    = AVG_W'(total / held_count[hit]);
         res.slot       = RSP_SLOT_W'(hit);
         res.fill_count = RSP_FILL_W'(held_count[hit]);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (sender_live[i]) begin
            sender_live[i] = 1'b0;
            held_count[i]  = 0;
         end
         averages_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (averages_due.size() == 0) begin
               report_mismatch($sformatf("result beat %0h with nothing expected", rsp_data));
            end else begin
               want = averages_due.pop_front();
               if (want.table_full)
                  full_results++;
               if (rsp_data.average !== want.average)
                  report_mismatch($sformatf("average got %0h expected %0h",
                                            rsp_data.average, want.average));
               if (rsp_data.slot !== want.slot)
                  report_mismatch($sformatf("slot got %0h expected %0h",
                                            rsp_data.slot, want.slot));
               if (rsp_data.fill_count !== want.fill_count)
                  report_mismatch($sformatf("fill_count got %0h expected %0h",
                                            rsp_data.fill_count, want.fill_count));
               if (rsp_data.table_full !== want.table_full)
                  report_mismatch($sformatf("table_full got %0h expected %0h",
                                            rsp_data.table_full, want.table_full));
            end
         end
         if (req_valid && !req_stall)
            averages_due.push_back(next_average(req_data));
      end
      pending <= averages_due.size();
   end

endmodule

### tb/sv/tb_per_source_moving_average.sv
// testbench top: stimulus, idling phases and verdict for the moving average block
`timescale 1ns / 100ps

module tb_per_source_moving_average;
   import psma_pkg::*;

   localparam int  ITEMS_PER_PHASE = 200;
   localparam int  DRAIN_CYCLES    = 60;
   localparam int  CYCLE_LIMIT     = 400000;
   localparam int  POOL_SIZE       = TABLE_ENTRIES;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int checked;
   int full_seen;

   int cycle_count = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int beats_sent  = 0;

   // senders that fill the table; the first few are address extremes
   logic [2*ADDR_HALF_W-1:0] sender_pool [POOL_SIZE];

   always #4 clock = ~clock;

   per_source_moving_average u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   psma_average_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .full_seen  (full_seen)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("[per_source_moving_average] ERROR");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

   task automatic send_reading(input logic [2*ADDR_HALF_W-1:0] key,
                               input logic [AVG_W-1:0] level);
      req_data  <= {key, level};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   function automatic logic [AVG_W-1:0] pick_level();
      logic [AVG_W-1:0] corner [4];
      corner = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE};
      if ($urandom_range(3) == 0)
         return corner[$urandom_range(3)];
      return AVG_W'($urandom_range(16'hFFFF));
   endfunction

   function automatic logic [2*ADDR_HALF_W-1:0] pick_sender();
      int roll;
      logic [2*ADDR_HALF_W-1:0] key;
      roll = $urandom_range(99);
      key  = sender_pool[$urandom_range(POOL_SIZE - 1)];
      // mostly known senders; strangers and near misses that match no known sender hit the full table
      if (roll >= 93)
         key = {$urandom, $urandom, $urandom, $urandom};
      else if (roll >= 85)
         key = key ^ ({{(2*ADDR_HALF_W-1){1'b0}}, 1'b1} << $urandom_range(2*ADDR_HALF_W-1));
      return key;
   endfunction

   initial begin
      int phase;
      int i;
      sender_pool[0] = '0;
      sender_pool[1] = '1;
      sender_pool[2] = {{ADDR_HALF_W{1'b1}}, {ADDR_HALF_W{1'b0}}};
      sender_pool[3] = {{ADDR_HALF_W{1'b0}}, {ADDR_HALF_W{1'b1}}};
      sender_pool[4] = 128'h1;
      sender_pool[5] = {1'b1, 127'b0};
      for (i = 6; i < POOL_SIZE; i++)
         sender_pool[i] = {$urandom, $urandom, $urandom, $urandom};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // one sender: window fills with the largest level, then the oldest drops out
      repeat (WINDOW) send_reading(sender_pool[0], 16'hFFFF);
      send_reading(sender_pool[0], 16'h0000);
      send_reading(sender_pool[0], 16'h0001);
      // remaining senders fill every entry, keys differing in a single bit included
      for (i = 1; i < POOL_SIZE; i++)
         send_reading(sender_pool[i], AVG_W'(16'h8000 >> i));
      // two strangers find the table full, then the last pool sender still finds its entry
      send_reading(~sender_pool[6], 16'hFFFF);
      send_reading(sender_pool[1] ^ 128'h2, 16'h1234);
      send_reading(sender_pool[POOL_SIZE-1], 16'hFFFF);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct <= 0;  stall_pct <= 0;  end
            1: begin idle_pct <= 76; stall_pct <= 0;  end
            2: begin idle_pct <= 0;  stall_pct <= 76; end
            default: begin idle_pct <= 8; stall_pct <= 8; end
         endcase
         repeat (ITEMS_PER_PHASE) send_reading(pick_sender(), pick_level());
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d request beats over four idling phases, %0d results checked",
               beats_sent, checked);
      $display("summary: %0d of them from a full table, %0d mismatches",
               full_seen, fail_count);
      if (fail_count == 0) begin
         $display("[per_source_moving_average] OK");
      end else begin
         $display("[per_source_moving_average] ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/psma_pkg.sv
rtl/psma_ram.sv
rtl/psma_ctrl.sv
rtl/psma_dp.sv
rtl/per_source_moving_average.sv
tb/sv/psma_average_checker.sv
tb/sv/tb_per_source_moving_average.sv
